// ===== hw/rtl/sc_pkg.sv =====
// Package for the sine/cosine series pipeline: Q.48 and Q30 constants, widths and
// the bus type passed between series term stages. No dependencies.
package sc_pkg;

   localparam int TERMS_DEFAULT = 18;
   localparam int FRAC_BITS     = 48;
   localparam int RED_STEPS     = 5;
   localparam int RES_W         = 14;
   localparam int X_W           = 57;

   localparam logic [63:0] TWO_PI_Q48  = 64'h0006487ED5110B46;
   localparam logic [63:0] HALF_PI_Q48 = 64'h0001921FB54442D2;
   localparam logic [63:0] ONE_Q30     = 64'h0000000040000000;

   typedef enum logic {
      OP_SINE   = 1'b0,
      OP_COSINE = 1'b1
   } opcode_type;

   typedef struct packed {
      logic               valid;
      logic               neg;
      logic [63:0]        t;
      logic [63:0]        x2;
      logic signed [63:0] sum;
   } term_bus_type;

endpackage

// ===== hw/rtl/sc_mul64.sv =====
// Two-stage 64x64 unsigned multiplier built from four 32x32 partial products.
// Depends on nothing.
module sc_mul64 (
   input  logic          clock,
   input  logic          en,
   input  logic [63:0]   a,
   input  logic [63:0]   b,
   output logic [127:0]  prod
);

   logic [63:0]  ll_ff, lh_ff, hl_ff, hh_ff;
   logic [127:0] prod_ff, prod_in;

   always_ff @(posedge clock) begin
      if (en) begin
         ll_ff <= a[31:0]  * b[31:0];
         lh_ff <= a[31:0]  * b[63:32];
         hl_ff <= a[63:32] * b[31:0];
         hh_ff <= a[63:32] * b[63:32];
      end
   end

   always_comb begin
      prod_in = {hh_ff, 64'd0} + {32'd0, lh_ff, 32'd0} + {32'd0, hl_ff, 32'd0}
              + {64'd0, ll_ff};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
      end
   end

   assign prod = prod_ff;

endmodule

// ===== hw/rtl/sc_front.sv =====
// Front end: cosine offset, magnitude and sign, and reduction modulo 2*pi
// by restoring subtraction. Depends on sc_pkg.
module sc_front
   import sc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  logic               in_opcode,
   input  logic signed [31:0] in_angle,
   output logic               out_valid,
   output logic               out_neg,
   output logic [63:0]        out_x
);

   localparam logic [X_W-1:0] TP = X_W'(TWO_PI_Q48);

   logic               v_valid_ff;
   logic signed [57:0] v_ff, v_in, av;
   logic [57:0]        neg_v;

   logic               red_valid_ff [0:RED_STEPS];
   logic               red_neg_ff   [0:RED_STEPS];
   logic [X_W-1:0]     red_x_ff     [0:RED_STEPS];

   always_comb begin
      av = {{2{in_angle[31]}}, in_angle, 24'd0};
      if (opcode_type'(in_opcode) == OP_COSINE) begin
         v_in = $signed(58'(HALF_PI_Q48)) - av;
      end else begin
         v_in = av;
      end
      neg_v = 58'(-v_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_valid_ff <= 1'b0;
      end else if (en) begin
         v_valid_ff <= in_valid;
      end
      if (en) begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         red_valid_ff[0] <= 1'b0;
      end else if (en) begin
         red_valid_ff[0] <= v_valid_ff;
      end
      if (en) begin
         red_neg_ff[0] <= v_ff[57] || (v_ff == 58'sd0);
         red_x_ff[0]   <= v_ff[57] ? neg_v[X_W-1:0] : v_ff[X_W-1:0];
      end
   end

   for (genvar i = 0; i < RED_STEPS; i++) begin : g_red
      localparam logic [X_W-1:0] SUB = TP << (RED_STEPS - 1 - i);
      always_ff @(posedge clock) begin
         if (reset) begin
            red_valid_ff[i+1] <= 1'b0;
         end else if (en) begin
            red_valid_ff[i+1] <= red_valid_ff[i];
         end
         if (en) begin
            red_neg_ff[i+1] <= red_neg_ff[i];
            red_x_ff[i+1]   <= (red_x_ff[i] >= SUB) ? red_x_ff[i] - SUB : red_x_ff[i];
         end
      end
   end

   assign out_valid = red_valid_ff[RED_STEPS];
   assign out_neg   = red_neg_ff[RED_STEPS];
   assign out_x     = {{(64-X_W){1'b0}}, red_x_ff[RED_STEPS]};

endmodule

// ===== hw/rtl/sc_term.sv =====
// One series term: exact division by 2k(2k+1) through a reciprocal product
// with one correction, then the product with x^2 and the accumulation.
// Depends on sc_pkg and sc_mul64.
module sc_term
   import sc_pkg::*;
#(
   parameter int K = 1
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         en,
   input  term_bus_type bus_in,
   output term_bus_type bus_out
);

   localparam int unsigned     D    = 2 * K * (2 * K + 1);
   localparam logic [64:0]     D_W  = 65'(D);
   localparam logic [64:0]     MF_W = (65'd1 << 64) / D_W;
   localparam logic [63:0]     MF   = MF_W[63:0];
   localparam logic [RES_W-1:0] D_R = RES_W'(D);
   localparam bit              SUB  = K[0];

   term_bus_type a_ff [0:1];
   term_bus_type c_ff, c_in;
   term_bus_type e_ff [0:1];
   term_bus_type f_ff, f_in;

   logic [127:0]      prod1, prod2;
   logic [63:0]       q0, tn;
   logic [RES_W-1:0]  qd, res;

   sc_mul64 u_div (
      .clock (clock),
      .en    (en),
      .a     (bus_in.t),
      .b     (MF),
      .prod  (prod1)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff[0].valid <= 1'b0;
         a_ff[1].valid <= 1'b0;
      end else if (en) begin
         a_ff[0] <= bus_in;
         a_ff[1] <= a_ff[0];
      end
   end

   always_comb begin
      q0       = prod1[127:64];
      qd       = q0[RES_W-1:0] * D_R;
      res      = a_ff[1].t[RES_W-1:0] - qd;
      c_in     = a_ff[1];
      c_in.t   = q0 + {63'd0, (res >= D_R)};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_ff.valid <= 1'b0;
      end else if (en) begin
         c_ff <= c_in;
      end
   end

   sc_mul64 u_sq (
      .clock (clock),
      .en    (en),
      .a     (c_ff.t),
      .b     (c_ff.x2),
      .prod  (prod2)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         e_ff[0].valid <= 1'b0;
         e_ff[1].valid <= 1'b0;
      end else if (en) begin
         e_ff[0] <= c_ff;
         e_ff[1] <= e_ff[0];
      end
   end

   always_comb begin
      tn     = prod2[FRAC_BITS+63:FRAC_BITS];
      f_in   = e_ff[1];
      f_in.t = tn;
      if (SUB) begin
         f_in.sum = e_ff[1].sum - $signed(tn);
      end else begin
         f_in.sum = e_ff[1].sum + $signed(tn);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_ff.valid <= 1'b0;
      end else if (en) begin
         f_ff <= f_in;
      end
   end

   assign bus_out = f_ff;

endmodule

// ===== hw/rtl/sine_cosine_series.sv =====
// Top level of the sine/cosine Taylor series pipeline.
// Depends on sc_pkg, sc_front, sc_mul64 and sc_term.
//
//   channel   direction  ports                          meaning
//   req_      in         req_opcode, req_angle          opcode, Q8.24 angle
//   rsp_      out        rsp_value                      Q2.30 result
//
// One request enters per cycle while the pipeline is not stalled; each
// series term adds 6 stages (two two-stage multipliers plus division
// correction and accumulation).
// Synchronous reset clears every stage valid bit.
// A stalled result freezes the whole pipeline; req_stall follows it.
module sine_cosine_series
   import sc_pkg::*;
#(
   parameter int TERMS = TERMS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_opcode,
   input  logic signed [31:0] req_angle,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_value
);

   logic               en;
   logic               f_valid, f_neg;
   logic [63:0]        f_x;
   logic [127:0]       sq_prod;
   logic               sq_valid_ff [0:1];
   logic               sq_neg_ff   [0:1];
   logic [63:0]        sq_x_ff     [0:1];
   term_bus_type       bus [0:TERMS-1];

   logic               o1_valid_ff, o1_neg_ff;
   logic [63:0]        o1_m_ff;
   logic               o2_valid_ff, o2_neg_ff;
   logic [30:0]        o2_m_ff, o2_m_in;
   logic [63:0]        rnd;
   logic               rsp_valid_ff;
   logic signed [31:0] rsp_value_ff;
   logic signed [63:0] last_sum;
   logic [63:0]        last_neg_sum;

   assign en        = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !en;

   sc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .in_opcode (req_opcode),
      .in_angle  (req_angle),
      .out_valid (f_valid),
      .out_neg   (f_neg),
      .out_x     (f_x)
   );

   sc_mul64 u_square (
      .clock (clock),
      .en    (en),
      .a     (f_x),
      .b     (f_x),
      .prod  (sq_prod)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_valid_ff[0] <= 1'b0;
         sq_valid_ff[1] <= 1'b0;
      end else if (en) begin
         sq_valid_ff[0] <= f_valid;
         sq_valid_ff[1] <= sq_valid_ff[0];
      end
      if (en) begin
         sq_neg_ff[0] <= f_neg;
         sq_neg_ff[1] <= sq_neg_ff[0];
         sq_x_ff[0]   <= f_x;
         sq_x_ff[1]   <= sq_x_ff[0];
      end
   end

   always_comb begin
      bus[0].valid = sq_valid_ff[1];
      bus[0].neg   = sq_neg_ff[1];
      bus[0].t     = sq_x_ff[1];
      bus[0].x2    = sq_prod[FRAC_BITS+63:FRAC_BITS];
      bus[0].sum   = $signed(sq_x_ff[1]);
   end

   for (genvar k = 1; k < TERMS; k++) begin : g_term
      sc_term #(
         .K (k)
      ) u_term (
         .clock   (clock),
         .reset   (reset),
         .en      (en),
         .bus_in  (bus[k-1]),
         .bus_out (bus[k])
      );
   end

   always_comb begin
      last_sum     = bus[TERMS-1].sum;
      last_neg_sum = 64'(-last_sum);
      rnd          = o1_m_ff + (64'd1 << 17);
      if ((rnd >> 18) > ONE_Q30) begin
         o2_m_in = ONE_Q30[30:0];
      end else begin
         o2_m_in = rnd[48:18];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         o1_valid_ff  <= 1'b0;
         o2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         o1_valid_ff  <= bus[TERMS-1].valid;
         o2_valid_ff  <= o1_valid_ff;
         rsp_valid_ff <= o2_valid_ff;
      end
      if (en) begin
         o1_neg_ff    <= last_sum[63] != bus[TERMS-1].neg;
         o1_m_ff      <= last_sum[63] ? last_neg_sum : last_sum;
         o2_neg_ff    <= o1_neg_ff;
         o2_m_ff      <= o2_m_in;
         rsp_value_ff <= o2_neg_ff ? -$signed({1'b0, o2_m_ff}) : $signed({1'b0, o2_m_ff});
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_value = rsp_value_ff;

endmodule

// ===== hw/rtl/sc_checker.sv =====
// Port-level checker for sine_cosine_series, attached by bind.
// Depends on nothing beyond the top level's ports.
module sc_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [31:0] rsp_value
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_value))
      else $error("stalled result changed");

   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($signed(rsp_value) <= 32'sd1073741824)
                 && ($signed(rsp_value) >= -32'sd1073741824))
      else $error("result beyond plus or minus one");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without a stalled result");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind sine_cosine_series sc_checker u_sc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_value (rsp_value)
);

// ===== tb/sine_cosine_series_test.sv =====
// Self-checking testbench for sine_cosine_series: a queue-fed driver, a
// stalling monitor and a Q.48 series predictor. Depends on sc_pkg and the RTL.
`timescale 1ns / 1ps
module sine_cosine_series_test;
   import sc_pkg::*;

   localparam logic [63:0] PI_Q48 = 64'h0003243F6A8885A3;
   localparam int SERIES_TERMS = TERMS_DEFAULT;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES = 12 + 6 * (SERIES_TERMS - 1) + 20;

   typedef struct packed {
      opcode_type         opcode;
      logic signed [31:0] angle;
   } request_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic               req_opcode;
   logic signed [31:0] req_angle;
   logic               rsp_valid;
   logic               rsp_stall;
   logic signed [31:0] rsp_value;

   request_type        pending_requests[$];
   logic signed [31:0] expected_values[$];
   int                 failures = 0;
   int                 sent = 0;
   int                 received = 0;
   int                 send_gap = 0;
   int                 recv_gap = 0;
   int                 hold_requests = 0;
   int                 holds_done = 0;
   int                 hold_count = 0;
   int                 idle_cycles = 0;
   bit                 no_idle = 0;

   sine_cosine_series dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_opcode(req_opcode), .req_angle(req_angle),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_value(rsp_value)
   );

   function automatic logic [63:0] mul_q48(logic [63:0] a, logic [63:0] b);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      return p[111:48];
   endfunction

   function automatic logic signed [31:0] series_value(opcode_type op,
                                                       logic signed [31:0] angle);
      logic signed [63:0] v;
      logic signed [63:0] sum;
      logic [63:0]        x, x2, t, m;
      logic               neg_in, neg_sum;
      v = 64'(angle) <<< 24;
      if (op == OP_COSINE)
         v = $signed(HALF_PI_Q48) - v;
      neg_in = !(v > 0);
      x = (v < 0) ? -v : v;
      if (x > PI_Q48)
         x = x - (x / TWO_PI_Q48) * TWO_PI_Q48;
      x2 = mul_q48(x, x);
      t = x;
      sum = $signed(x);
      for (int k = 1; k < SERIES_TERMS; k++) begin
         t = t / (64'(2 * k) * 64'(2 * k + 1));
         t = mul_q48(t, x2);
         if (k % 2 == 1)
            sum = sum - $signed(t);
         else
            sum = sum + $signed(t);
      end
      neg_sum = sum < 0;
      m = neg_sum ? -sum : sum;
      m = (m + 64'h20000) >> 18;
      if (m > ONE_Q30)
         m = ONE_Q30;
      if (neg_sum != neg_in)
         m = -m;
      return m[31:0];
   endfunction

   function automatic int pick_gap();
      if (no_idle || $urandom_range(0, 9) < 6)
         return 0;
      if ($urandom_range(0, 9) < 8)
         return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      request_type next_req;
      logic        next_valid;
      if (reset) begin
         req_valid  <= 0;
         req_opcode <= 0;
         req_angle  <= 0;
      end else begin
         next_valid = req_valid;
         if (req_valid && !req_stall) begin
            expected_values.push_back(series_value(opcode_type'(req_opcode), req_angle));
            sent++;
            next_valid = 0;
            send_gap = pick_gap();
         end
         if (!next_valid) begin
            if (send_gap > 0)
               send_gap--;
            else if (pending_requests.size() > 0) begin
               next_req = pending_requests.pop_front();
               next_valid = 1;
               req_opcode <= next_req.opcode;
               req_angle  <= next_req.angle;
            end
         end
         req_valid <= next_valid;
      end
   end

   always @(posedge clock) begin
      logic signed [31:0] want;
      if (reset) begin
         rsp_stall <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            received++;
            if (expected_values.size() == 0) begin
               $error("value: unexpected result %0d", rsp_value);
               failures++;
            end else begin
               want = expected_values.pop_front();
               if (rsp_value !== want) begin
                  $error("value: expected %0d actual %0d", want, rsp_value);
                  failures++;
               end
            end
         end
         if (holds_done < hold_requests) begin
            holds_done++;
            hold_count = 400;
         end
         if (hold_count > 0) begin
            hold_count--;
            rsp_stall <= 1;
         end else if (recv_gap > 0) begin
            recv_gap--;
            rsp_stall <= 1;
         end else begin
            recv_gap = pick_gap();
            rsp_stall <= 0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout after %0d idle cycles", idle_cycles);
         $display("sine_cosine_series: mismatch");
         $finish;
      end else
         idle_cycles <= idle_cycles + 1;
   end

   task automatic add_request(opcode_type op, logic signed [31:0] angle);
      request_type r;
      r.opcode = op;
      r.angle  = angle;
      pending_requests.push_back(r);
   endtask

   task automatic wait_drained();
      while (pending_requests.size() > 0 || req_valid || expected_values.size() > 0)
         @(posedge clock);
   endtask

   task automatic add_random(int count);
      logic signed [31:0] a;
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(0, 4))
            0: a = $urandom;
            1: a = $signed($urandom_range(0, 2 * 210828714)) - 210828714;
            2: a = $signed($urandom_range(0, 2 * 52707179)) - 52707179;
            3: a = 52707178 * $signed($urandom_range(0, 80) - 40) +
                   $signed($urandom_range(0, 8)) - 4;
            default: a = $signed($urandom_range(0, 2000)) - 1000;
         endcase
         add_request(opcode_type'($urandom_range(0, 1)), a);
      end
   endtask

   initial begin
      logic signed [31:0] edges[$];
      reset = 1;
      repeat (4) @(posedge clock);
      reset <= 0;

      edges = '{32'sd0, 32'sd1, -32'sd1, 32'h7FFFFFFF, 32'h80000000,
                32'sd52707178, -32'sd52707178, 32'sd52707179, 32'sd26353589,
                -32'sd26353589, 32'sd105414357, 32'sd16777216, 32'h55555555};
      foreach (edges[i]) begin
         add_request(OP_SINE, edges[i]);
         add_request(OP_COSINE, edges[i]);
      end
      wait_drained();

      no_idle = 1;
      add_random(60);
      wait_drained();
      no_idle = 0;

      add_random(80);
      hold_requests = 1;
      add_random(100);
      wait_drained();

      add_random(160);
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("sent %0d requests (directed edges, sine and cosine, wrapped angles)", sent);
      $display("checked %0d results under random gaps and a long receiver hold", received);
      if (failures == 0 && expected_values.size() == 0)
         $display("sine_cosine_series: match");
      else
         $display("sine_cosine_series: mismatch");
      $finish;
   end

endmodule
